// ===== src/cfbse_pkg.sv =====
// shared types, constants and the byte-wide crc-32 update for the framing encoder
// no dependencies
package cfbse_pkg;

    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [7:0]  ESC_BYTE   = 8'h7D;
    localparam logic [7:0]  ESC_XOR    = 8'h20;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;
    localparam int          QUEUE_DEPTH = 2;
    localparam int          QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one classified word between the front and the back
    typedef struct packed {
        logic [7:0]  data;
        logic        open;   // opening flag goes out first
        logic        last;   // crc trailer and closing flag follow
        logic [31:0] fcs;    // inverted crc, valid when last is set
    } t_entry;

    typedef enum logic [2:0] {
        PH_START,
        PH_OPEN,
        PH_DATA,
        PH_CRC,
        PH_CLOSE
    } t_phase;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/cfbse_front.sv =====
// front of the framing encoder: tracks frame state and the running crc,
// classifies each byte into a queue word; depends on cfbse_pkg
module cfbse_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_frame_last,
    input  logic                  i_q_full,
    output logic                  o_q_wr,
    output cfbse_pkg::t_entry     o_q_entry
);
    import cfbse_pkg::*;

    logic        r_in_frame;
    logic        n_in_frame;
    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] crc_new;
    logic        accept;

    assign accept  = i_push && !i_q_full;
    assign crc_new = crc_byte(r_crc, i_in_byte);

    always_comb begin
        n_in_frame = r_in_frame;
        n_crc      = r_crc;
        if (accept) begin
            if (i_frame_last) begin
                n_in_frame = 1'b0;
                n_crc      = CRC_PRESET;
            end else begin
                n_in_frame = 1'b1;
                n_crc      = crc_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_crc      <= CRC_PRESET;
        end else begin
            r_in_frame <= n_in_frame;
            r_crc      <= n_crc;
        end
    end

    assign o_q_wr          = accept;
    assign o_q_entry.data  = i_in_byte;
    assign o_q_entry.open  = !r_in_frame;
    assign o_q_entry.last  = i_frame_last;
    assign o_q_entry.fcs   = ~crc_new;

endmodule

// ===== src/cfbse_queue.sv =====
// short word queue between the front and the back of the framing encoder
// depends on cfbse_pkg
module cfbse_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  cfbse_pkg::t_entry     i_entry,
    input  logic                  i_rd,
    output cfbse_pkg::t_entry     o_entry,
    output logic                  o_full,
    output logic                  o_empty
);
    import cfbse_pkg::*;

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wptr;
    logic [QUEUE_AW-1:0]   r_rptr;
    logic [QUEUE_AW:0]     r_count;
    logic [QUEUE_AW:0]     n_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (i_rd && !i_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= (r_wptr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= (r_rptr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full && !i_rd))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && o_empty))
        else $error("queue read while empty");

endmodule

// ===== src/cfbse_back.sv =====
// back of the framing encoder: walks each word through any opening flag, escaped data,
// if last, escaped crc and closing flag into the output register; depends on cfbse_pkg
module cfbse_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cfbse_pkg::t_entry     i_entry,
    input  logic                  i_q_empty,
    output logic                  o_q_rd,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [7:0]            o_out_byte,
    output logic                  o_run_last,
    output logic                  o_frame_end
);
    import cfbse_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    t_phase      ph;
    logic        r_esc;
    logic        n_esc;
    logic [1:0]  r_idx;
    logic [1:0]  n_idx;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_run_last;
    logic        r_frame_end;

    logic        go;
    logic [7:0]  crc_sel;
    logic [7:0]  src;
    logic        needs_esc;
    logic        byte_done;
    logic        done_entry;
    logic [7:0]  emit_byte;
    logic        emit_run_last;
    logic        emit_end;

    // the output register frees up in the same cycle it is popped
    assign go = !i_q_empty && (!r_out_valid || i_pop);

    always_comb begin
        case (r_idx)
            2'd0:    crc_sel = i_entry.fcs[31:24];
            2'd1:    crc_sel = i_entry.fcs[23:16];
            2'd2:    crc_sel = i_entry.fcs[15:8];
            default: crc_sel = i_entry.fcs[7:0];
        endcase
    end

    always_comb begin
        ph            = (r_phase == PH_START) ? (i_entry.open ? PH_OPEN : PH_DATA) : r_phase;
        src           = (ph == PH_CRC) ? crc_sel : i_entry.data;
        needs_esc     = (src == FLAG_BYTE) || (src == ESC_BYTE);
        n_phase       = ph;
        n_esc         = r_esc;
        n_idx         = r_idx;
        byte_done     = 1'b0;
        done_entry    = 1'b0;
        emit_byte     = FLAG_BYTE;
        emit_run_last = 1'b0;
        emit_end      = 1'b0;
        case (ph)
            PH_OPEN: begin
                n_phase = PH_DATA;
            end
            PH_DATA, PH_CRC: begin
                if (needs_esc && !r_esc) begin
                    emit_byte = ESC_BYTE;
                    n_esc     = 1'b1;
                end else begin
                    emit_byte = r_esc ? (src ^ ESC_XOR) : src;
                    n_esc     = 1'b0;
                    byte_done = 1'b1;
                end
                if (byte_done && ph == PH_DATA) begin
                    if (i_entry.last) begin
                        n_phase = PH_CRC;
                        n_idx   = 2'd0;
                    end else begin
                        emit_run_last = 1'b1;
                        done_entry    = 1'b1;
                        n_phase       = PH_START;
                    end
                end else if (byte_done) begin
                    if (r_idx == 2'd3) begin
                        n_phase = PH_CLOSE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            PH_CLOSE: begin
                emit_end      = 1'b1;
                emit_run_last = 1'b1;
                done_entry    = 1'b1;
                n_phase       = PH_START;
            end
            default: begin
                n_phase = PH_START;
            end
        endcase
    end

    assign o_q_rd = go && done_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_esc       <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (go) begin
                r_phase <= n_phase;
                r_esc   <= n_esc;
                r_idx   <= n_idx;
            end
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_byte  <= emit_byte;
            r_run_last  <= emit_run_last;
            r_frame_end <= emit_end;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_run_last;
    assign o_frame_end = r_frame_end;

    a_end_is_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_frame_end) |-> (r_out_byte == FLAG_BYTE && r_run_last))
        else $error("closing word is not a flag ending its run");

    a_esc_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> (r_phase == PH_DATA || r_phase == PH_CRC))
        else $error("escape pending outside data or crc");

    a_esc_precedes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && r_esc) |=> (r_out_byte != FLAG_BYTE && r_out_byte != ESC_BYTE))
        else $error("escaped word leaves a reserved value");

endmodule

// ===== src/crc_framed_byte_stuffing_encoder_core.sv =====
// Framing encoder, top level: HDLC-style byte stuffing with a CRC-32 trailer.
// Input channel: push/full carries one unframed byte and its frame_last mark;
// a word is taken at a clock edge with push high and full low.
// Output channel: empty/pop presents one line byte at a time; run_last marks
// the final line byte caused by an input word, frame_end marks the closing flag.
// The front updates the running CRC as it accepts a byte and writes a
// classified word into a 2-deep queue; the back expands each word into 1 to
// 12 line bytes, one per cycle while the receiver pops, into an output register.
// With the back idle, a taken word is written into the queue and its first line
// byte is then loaded into the output register. Throughput: one line byte per
// cycle while the receiver pops, set by the single output register.
// Input is taken whenever the queue has room, also while results wait.
// Reset (synchronous, active low) closes any open frame, presets the CRC to
// all ones and empties the queue and output register.
// A stalled receiver holds the output byte; the queue then fills and full rises.
// depends on cfbse_pkg, cfbse_front, cfbse_queue, cfbse_back
module crc_framed_byte_stuffing_encoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_frame_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_frame_end
);
    import cfbse_pkg::*;

    t_entry wr_entry;
    t_entry rd_entry;
    logic   q_wr;
    logic   q_rd;
    logic   q_full;
    logic   q_empty;

    cfbse_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_in_byte    (i_in_byte),
        .i_frame_last (i_frame_last),
        .i_q_full     (q_full),
        .o_q_wr       (q_wr),
        .o_q_entry    (wr_entry)
    );

    cfbse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_entry (wr_entry),
        .i_rd    (q_rd),
        .o_entry (rd_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cfbse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (rd_entry),
        .i_q_empty   (q_empty),
        .o_q_rd      (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_frame_end (o_frame_end)
    );

    assign full = q_full;

endmodule

// ===== tb/sv/crc_framed_byte_stuffing_encoder_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the crc-32 byte-stuffing framer: queued command bytes
// in, line words checked against an in-bench framing and crc predictor
// depends on cfbse_pkg and crc_framed_byte_stuffing_encoder_core
module crc_framed_byte_stuffing_encoder_core_tb;

    import cfbse_pkg::*;

    localparam int WDOG_LIMIT = 2500;
    localparam int N_RAND_WORDS = 340;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_cmd_word;

    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } t_line_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_frame_last = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_frame_end;

    t_cmd_word  cmd_q[$];
    t_line_word line_exp_q[$];

    // predictor state
    logic        frame_open = 1'b0;
    logic [31:0] crc_run = CRC_PRESET;

    int err_cnt = 0;
    int words_in = 0;
    int words_out = 0;
    int frames_done = 0;
    int escapes = 0;
    int idle_cnt = 0;

    int tx_gap = 0;
    int rx_wait = 0;
    int rx_hold = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    crc_framed_byte_stuffing_encoder_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in_byte    (i_in_byte),
        .i_frame_last (i_frame_last),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_frame_end  (o_frame_end)
    );

    always #5 i_clk = ~i_clk;

    // reflected crc-32, lsb first, one data byte
    function automatic logic [31:0] crc32_shift_byte(input logic [31:0] crc,
                                                     input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'h0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    task automatic push_line(input logic [7:0] data, input logic fend);
        t_line_word w;
        w.out_byte = data;
        w.run_last = 1'b0;
        w.frame_end = fend;
        line_exp_q.push_back(w);
    endtask

    task automatic push_stuffed(input logic [7:0] data);
        if (data == FLAG_BYTE || data == ESC_BYTE) begin
            push_line(ESC_BYTE, 1'b0);
            push_line(data ^ ESC_XOR, 1'b0);
            escapes++;
        end else begin
            push_line(data, 1'b0);
        end
    endtask

    // expected line words for one accepted command byte
    task automatic frame_line_bytes(input logic [7:0] data, input logic last);
        logic [31:0] fcs;
        if (!frame_open) begin
            push_line(FLAG_BYTE, 1'b0);
            frame_open = 1'b1;
            crc_run = CRC_PRESET;
        end
        push_stuffed(data);
        crc_run = crc32_shift_byte(crc_run, data);
        if (last) begin
            fcs = ~crc_run;
            push_stuffed(fcs[31:24]);
            push_stuffed(fcs[23:16]);
            push_stuffed(fcs[15:8]);
            push_stuffed(fcs[7:0]);
            push_line(FLAG_BYTE, 1'b1);
            frame_open = 1'b0;
            crc_run = CRC_PRESET;
            frames_done++;
        end
        line_exp_q[line_exp_q.size() - 1].run_last = 1'b1;
    endtask

    task automatic add_cmd(input logic [7:0] data, input logic last);
        t_cmd_word c;
        c.data = data;
        c.last = last;
        cmd_q.push_back(c);
    endtask

    // two-byte command whose trailer has the given value at the given byte position
    task automatic add_trailer_escape(input int pos, input logic [7:0] target);
        logic [31:0] fcs;
        bit found;
        found = 1'b0;
        for (int a = 0; a < 256 && !found; a++) begin
            for (int b = 0; b < 256 && !found; b++) begin
                fcs = ~crc32_shift_byte(crc32_shift_byte(CRC_PRESET, a[7:0]), b[7:0]);
                if (fcs[8 * (3 - pos) +: 8] == target) begin
                    add_cmd(a[7:0], 1'b0);
                    add_cmd(b[7:0], 1'b1);
                    found = 1'b1;
                end
            end
        end
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 11))
            0: return FLAG_BYTE;
            1: return ESC_BYTE;
            2: return FLAG_BYTE ^ ESC_XOR;
            3: return ESC_BYTE ^ ESC_XOR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // sender: keeps push high across back-to-back words
    always @(posedge i_clk) begin : drv_proc
        logic nxt_push;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            nxt_push = push;
            if (push && !full) begin
                frame_line_bytes(cmd_q[0].data, cmd_q[0].last);
                cmd_q.delete(0);
                words_in++;
                if ($urandom_range(0, 24) == 0) tx_burst = !tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 13);
                nxt_push = 1'b0;
            end
            if (!nxt_push) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (cmd_q.size() > 0) begin
                    nxt_push = 1'b1;
                    i_in_byte <= cmd_q[0].data;
                    i_frame_last <= cmd_q[0].last;
                end
            end
            push <= nxt_push;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : mon_proc
        t_line_word want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                words_out++;
                if (line_exp_q.size() == 0) begin
                    $error("unexpected line word out_byte=0x%02h", o_out_byte);
                    err_cnt++;
                end else begin
                    want = line_exp_q.pop_front();
                    if (o_out_byte !== want.out_byte) begin
                        $error("out_byte: expected 0x%02h, got 0x%02h",
                               want.out_byte, o_out_byte);
                        err_cnt++;
                    end
                    if (o_run_last !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b", want.run_last, o_run_last);
                        err_cnt++;
                    end
                    if (o_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, got %0b",
                               want.frame_end, o_frame_end);
                        err_cnt++;
                    end
                end
                // long stall so the queue fills and full backs up the sender
                if (words_out == 40 || words_out == 500) rx_hold = $urandom_range(200, 300);
                if ($urandom_range(0, 24) == 0) rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 13);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                pop <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : wdog_proc
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                idle_cnt = 0;
            end else begin
                idle_cnt++;
            end
            if (idle_cnt >= WDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : main_proc
        int n_rand;
        int len;
        // single-byte commands, plain and escaped
        add_cmd(8'h00, 1'b1);
        add_cmd(8'hFF, 1'b1);
        add_cmd(FLAG_BYTE, 1'b1);
        add_cmd(ESC_BYTE, 1'b1);
        // escapes right after the opening flag and back to back
        add_cmd(FLAG_BYTE, 1'b0);
        add_cmd(ESC_BYTE, 1'b0);
        add_cmd(FLAG_BYTE ^ ESC_XOR, 1'b0);
        add_cmd(ESC_BYTE ^ ESC_XOR, 1'b0);
        add_cmd(ESC_XOR, 1'b0);
        add_cmd(8'hA5, 1'b0);
        add_cmd(8'h00, 1'b1);
        // escaped bytes inside the crc trailer
        add_trailer_escape(0, FLAG_BYTE);
        add_trailer_escape(1, ESC_BYTE);
        add_trailer_escape(2, FLAG_BYTE);
        add_trailer_escape(3, ESC_BYTE);

        n_rand = 0;
        while (n_rand < N_RAND_WORDS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                add_cmd(pick_data(), i == len - 1);
            end
            n_rand += len;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || push || line_exp_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (30) @(negedge i_clk);

        $display("sent %0d command words in %0d frames, checked %0d line words",
                 words_in, frames_done, words_out);
        $display("%0d stuffed bytes, including escapes inside crc trailers", escapes);
        if (err_cnt == 0 && line_exp_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== crc_framed_byte_stuffing_encoder_core.f =====
src/cfbse_pkg.sv
src/cfbse_front.sv
src/cfbse_queue.sv
src/cfbse_back.sv
src/crc_framed_byte_stuffing_encoder_core.sv
tb/sv/crc_framed_byte_stuffing_encoder_core_tb.sv
